// ----- rtl/core/i8dq_pkg.sv -----
// Package for the int8 group dequantizer: constants, the per-lane product function and the bfloat16 rounding function.
package i8dq_pkg;

  localparam int unsigned LANES = 4;

  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
  localparam logic [7:0]  F32_EXP_INF = 8'hFF;

  // Binary32 bits of code * binary16 scale (exact).
  function automatic logic [31:0] lane_product(input logic [7:0] code, input logic [15:0] scale);
    logic        ssign;
    logic [4:0]  sexp;
    logic [9:0]  sman;
    logic        cneg;
    logic [7:0]  cmag;
    logic        rsign;
    logic [10:0] sig;
    logic [7:0]  ebase;
    logic [17:0] prod;
    logic [4:0]  p;
    logic [7:0]  bexp;
    logic [40:0] shifted;
    logic [31:0] res;
    ssign = scale[15];
    sexp  = scale[14:10];
    sman  = scale[9:0];
    cneg  = code[7];
    cmag  = cneg ? (8'd0 - code) : code;
    rsign = ssign ^ cneg;
    // Significand and biased exponent of prod bit 0: e2 + 127.
    if (sexp == 5'd0) begin
      sig   = {1'b0, sman};
      ebase = 8'd103;
    end else begin
      sig   = {1'b1, sman};
      ebase = 8'd102 + {3'd0, sexp};
    end
    prod = {10'd0, cmag} * {7'd0, sig};
    p = 5'd0;
    for (int i = 1; i < 18; i++) begin
      if (prod[i]) p = 5'(i);
    end
    bexp    = ebase + {3'd0, p};
    shifted = {23'd0, prod} << (5'd23 - p);
    if (sexp == 5'h1F) begin
      if (sman != 10'd0)
        res = {ssign, F32_EXP_INF, 1'b1, sman[8:0], 13'd0} | {22'd0, sman[9], 9'd0} << 13;
      else if (cmag == 8'd0)
        res = F32_QNAN;
      else
        res = {rsign, F32_EXP_INF, 23'd0};
    end else if (cmag == 8'd0) begin
      res = {ssign, 31'd0};
    end else if (sexp == 5'd0 && sman == 10'd0) begin
      res = {rsign, 31'd0};
    end else begin
      res = {rsign, bexp, shifted[22:0]};
    end
    return res;
  endfunction

  // Round a binary32 word to bfloat16, nearest even, no NaN special case.
  function automatic logic [15:0] rne_bf16(input logic [31:0] w);
    logic [31:0] s;
    s = w + 32'h0000_7FFF + {31'd0, w[16]};
    return s[31:16];
  endfunction

endpackage

// ----- rtl/core/int8_group_dequant_to_bf16_unit.sv -----
// Top level: int8 group dequantizer, four codes times binary16 scale to bfloat16.
// Path: an accepted beat is held in the input register, then in the result register, which drives out_valid.
// Throughput: one beat per cycle; busy is tied low, no stall path.
// The datapath is a single registered pass: input register, per-lane
// multiply/normalize/round logic, result register.
// Reset (rst_n, synchronous, active low) clears the input and output valid flags.
module int8_group_dequant_to_bf16_unit
  import i8dq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic signed [7:0] in_code_a,
  input  logic signed [7:0] in_code_b,
  input  logic signed [7:0] in_code_c,
  input  logic signed [7:0] in_code_d,
  input  logic [15:0]       in_group_scale,
  output logic              out_valid,
  output logic [15:0]       out_weight_a,
  output logic [15:0]       out_weight_b,
  output logic [15:0]       out_weight_c,
  output logic [15:0]       out_weight_d
);

  // Input stage
  logic        in_vld_r;
  logic [7:0]  code_r [LANES];
  logic [15:0] scale_r;
  // Result stage
  logic        out_vld_r;
  logic [15:0] wt_r [LANES];
  logic [15:0] wt_nxt [LANES];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      code_r[0] <= in_code_a;
      code_r[1] <= in_code_b;
      code_r[2] <= in_code_c;
      code_r[3] <= in_code_d;
      scale_r   <= in_group_scale;
    end
    if (in_vld_r) wt_r <= wt_nxt;
  end

  // One product and round per lane
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      wt_nxt[l] = rne_bf16(lane_product(code_r[l], scale_r));
    end
  end

  assign out_valid    = out_vld_r;
  assign out_weight_a = wt_r[0];
  assign out_weight_b = wt_r[1];
  assign out_weight_c = wt_r[2];
  assign out_weight_d = wt_r[3];

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the int8 group dequantizer: random and directed beats checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import i8dq_pkg::*;

  // One result beat: four bfloat16 weights.
  typedef struct packed {
    logic [15:0] wa;
    logic [15:0] wb;
    logic [15:0] wc;
    logic [15:0] wd;
  } weights_t;

  // Expected-weight store; notes accepted beats, checks result beats.
  class weight_scoreboard;
    weights_t pending[$];
    int       mismatches;

    // Binary32 bits of one code times the binary16 scale, exact.
    function automatic logic [31:0] scaled_code(logic [7:0] code, logic [15:0] scale);
      logic        ssign, cneg;
      logic [4:0]  sexp;
      logic [9:0]  sman;
      logic [7:0]  cmag;
      logic [10:0] sig;
      logic [17:0] prod;
      int          e2, msb, bexp;
      logic [31:0] frac;
      ssign = scale[15];
      sexp  = scale[14:10];
      sman  = scale[9:0];
      cneg  = code[7];
      cmag  = cneg ? 8'(-code) : code;
      if (sexp == 5'h1F) begin
        if (sman != 0) return {ssign, 8'hFF, 1'b1, sman[8:0], 13'd0};
        if (cmag == 0) return 32'h7FC0_0000;
        return {ssign ^ cneg, 31'h7F80_0000};
      end
      if (cmag == 0) return {ssign, 31'd0};
      if (sexp == 0) begin
        if (sman == 0) return {ssign ^ cneg, 31'd0};
        sig = {1'b0, sman};
        e2  = -24;
      end else begin
        sig = {1'b1, sman};
        e2  = int'(sexp) - 25;
      end
      prod = 18'(cmag) * 18'(sig);
      msb = 0;
      for (int i = 0; i < 18; i++) if (prod[i]) msb = i;
      bexp = msb + e2 + 127;
      frac = 32'(prod) << (23 - msb);
      return {ssign ^ cneg, 8'(bexp), frac[22:0]};
    endfunction

    // Round to bfloat16 by adding 0x7FFF plus the kept lsb; NaN gets no special care.
    function automatic logic [15:0] to_bf16(logic [31:0] w);
      logic [31:0] s;
      s = w + 32'h7FFF + 32'(w[16]);
      return s[31:16];
    endfunction

    function void note_input(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d,
                             logic [15:0] scale);
      weights_t e;
      e.wa = to_bf16(scaled_code(a, scale));
      e.wb = to_bf16(scaled_code(b, scale));
      e.wc = to_bf16(scaled_code(c, scale));
      e.wd = to_bf16(scaled_code(d, scale));
      pending = {pending, e};
    endfunction

    function void check_result(weights_t got);
      weights_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      e = pending.pop_front();
      if (e.wa !== got.wa || e.wb !== got.wb || e.wc !== got.wc || e.wd !== got.wd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("weight mismatch: exp a=%h b=%h c=%h d=%h got a=%h b=%h c=%h d=%h",
                   e.wa, e.wb, e.wc, e.wd, got.wa, got.wb, got.wc, got.wd);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic signed [7:0] in_code_a = '0, in_code_b = '0, in_code_c = '0, in_code_d = '0;
  logic [15:0]       in_group_scale = '0;
  logic              out_valid;
  logic [15:0]       out_weight_a, out_weight_b, out_weight_c, out_weight_d;

  weight_scoreboard sb;
  int unsigned      cycles;
  bit               stall_free;  // long burst stretch with no idle cycles

  always #5 clk = ~clk;

  int8_group_dequant_to_bf16_unit u_dut (
    .clk, .rst_n, .start, .busy,
    .in_code_a, .in_code_b, .in_code_c, .in_code_d, .in_group_scale,
    .out_valid, .out_weight_a, .out_weight_b, .out_weight_c, .out_weight_d
  );

  // Sample the input handshake and result strobe at the rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && start && !busy)
      sb.note_input(in_code_a, in_code_b, in_code_c, in_code_d, in_group_scale);
    if (rst_n && out_valid)
      sb.check_result({out_weight_a, out_weight_b, out_weight_c, out_weight_d});
    if (cycles > 200000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one beat, hold it until accepted; random idle cycles in front unless stall_free is set.
  task automatic send_beat(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d,
                           logic [15:0] scale);
    while (!stall_free && $urandom_range(99) < 21) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_code_a      <= a;
    in_code_b      <= b;
    in_code_c      <= c;
    in_code_d      <= d;
    in_group_scale <= scale;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Scale mix: mostly normals, with zeros, subnormals, infinities and NaNs.
  function automatic logic [15:0] pick_scale();
    logic [15:0] s;
    s = 16'($urandom);
    case ($urandom_range(9))
      0: s[14:10] = 5'h00;
      1: s[14:10] = 5'h1F;
      2: s[14:0]  = '0;
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'h80;
      2: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] dir_scales[12];
    sb = new();
    stall_free = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero, subnormal, max normal, infinities, quiet/signaling NaNs,
    // and the NaN whose rounding carries into the sign bit.
    dir_scales = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h3C00, 16'h7BFF,
                   16'hFBFF, 16'h7C00, 16'hFC00, 16'h7FFF, 16'h7D55, 16'hFE01};
    foreach (dir_scales[i]) begin
      send_beat(8'h00, 8'h80, 8'h7F, 8'hFF, dir_scales[i]);
      send_beat(8'h01, 8'h81, 8'h55, 8'hAA, dir_scales[i]);
    end

    for (int n = 0; n < 1450; n++) begin
      stall_free = (n >= 600 && n < 800);
      send_beat(pick_code(), pick_code(), pick_code(), pick_code(), pick_scale());
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/i8dq_pkg.sv
rtl/core/int8_group_dequant_to_bf16_unit.sv
tb/tb_top.sv
